### hw/rtl/pig_pkg.sv
// Shared types and constants for the prime implicant generator.
// No dependencies.
package pig_pkg;

    localparam int FIELD_W  = 4;
    localparam int CFG_W    = 3;
    localparam int MAX_RES  = 32;
    localparam int CNT_W    = 6;
    localparam logic [CFG_W-1:0] NUM_VARS_RST = 3'd4;

    localparam logic [1:0] DIG_ZERO = 2'd0;
    localparam logic [1:0] DIG_ONE  = 2'd1;
    localparam logic [1:0] DIG_DASH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    typedef struct packed {
        logic [FIELD_W-1:0] care_mask;
        logic [FIELD_W-1:0] value_bits;
        logic               empty_res;
        logic               last_result;
    } t_result;

endpackage

### hw/rtl/pig_cube_unit.sv
// Shared cube test unit: checks that a cube lies in the on-set and that no
// single-variable widening of it does. Depends on pig_pkg.
module pig_cube_unit import pig_pkg::*; #(
    parameter int MAX_VARS = 4
) (
    input  logic [(1<<MAX_VARS)-1:0] i_onset,
    input  logic [(1<<MAX_VARS)-1:0] i_live,
    input  logic [MAX_VARS-1:0]      i_care,
    input  logic [MAX_VARS-1:0]      i_val,
    output logic                     o_prime
);

    localparam int NSPAN = 1 << MAX_VARS;

    function automatic logic f_inside(input logic [NSPAN-1:0] on,
                                      input logic [NSPAN-1:0] live,
                                      input logic [MAX_VARS-1:0] c,
                                      input logic [MAX_VARS-1:0] v);
        logic                ok;
        logic [MAX_VARS-1:0] mi;
        ok = 1'b1;
        for (int m = 0; m < NSPAN; m++) begin
            mi = MAX_VARS'(m);
            if (live[m] && ((mi & c) == v) && !on[m]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    logic [MAX_VARS-1:0] bitp;

    always_comb begin
        o_prime = f_inside(i_onset, i_live, i_care, i_val);
        bitp    = '0;
        for (int p = 0; p < MAX_VARS; p++) begin
            bitp = MAX_VARS'(1) << p;
            if (i_care[p] && f_inside(i_onset, i_live, i_care & ~bitp, i_val & ~bitp)) begin
                o_prime = 1'b0;
            end
        end
    end

endmodule

### hw/rtl/pig_scan.sv
// Scan sequencer: walks cubes in base-3 order, one per cycle, through the
// shared cube unit and strobes the primes. Depends on pig_pkg, pig_cube_unit.
module pig_scan import pig_pkg::*; #(
    parameter int MAX_VARS = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  logic [CFG_W-1:0]         i_nact,
    input  logic [(1<<MAX_VARS)-1:0] i_onset,
    input  logic [(1<<MAX_VARS)-1:0] i_live,
    output logic                     o_busy,
    output logic                     o_clear,
    output logic                     o_res_valid,
    output t_result                  o_res
);

    t_state              r_state, n_state;
    logic [1:0]          r_dig [MAX_VARS];
    logic [1:0]          n_dig [MAX_VARS];
    logic [MAX_VARS-1:0] pos_live;
    logic [MAX_VARS-1:0] care, val;
    logic                carry, last_code, prime;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_pend_v;
    logic [MAX_VARS-1:0] r_pend_care, r_pend_val;
    logic                r_valid;
    t_result             r_res;

    always_comb begin
        last_code = 1'b1;
        carry     = 1'b1;
        for (int p = 0; p < MAX_VARS; p++) begin
            pos_live[p] = (p < int'(i_nact));
            care[p]     = pos_live[p] && (r_dig[p] != DIG_DASH);
            val[p]      = pos_live[p] && (r_dig[p] == DIG_ONE);
            n_dig[p]    = r_dig[p];
            if (pos_live[p]) begin
                if (r_dig[p] != DIG_DASH) begin
                    last_code = 1'b0;
                end
                if (carry) begin
                    if (r_dig[p] == DIG_DASH) begin
                        n_dig[p] = DIG_ZERO;
                    end else begin
                        n_dig[p] = r_dig[p] + 2'd1;
                        carry    = 1'b0;
                    end
                end
            end
        end
    end

    pig_cube_unit #(.MAX_VARS(MAX_VARS)) u_cube (
        .i_onset (i_onset),
        .i_live  (i_live),
        .i_care  (care),
        .i_val   (val),
        .o_prime (prime)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_go) n_state = ST_SCAN;
            ST_SCAN:  if (last_code) n_state = ST_FLUSH;
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend_v <= 1'b0;
            r_valid  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_pend_v <= 1'b0;
                    r_cnt    <= '0;
                end
                ST_SCAN: begin
                    if (prime && (r_cnt < CNT_W'(MAX_RES))) begin
                        r_valid  <= r_pend_v;
                        r_pend_v <= 1'b1;
                        r_cnt    <= r_cnt + 1'b1;
                    end
                end
                ST_FLUSH: begin
                    r_valid  <= 1'b1;
                    r_pend_v <= 1'b0;
                end
                default: begin
                    r_pend_v <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < MAX_VARS; p++) begin
            if (r_state == ST_IDLE) begin
                r_dig[p] <= DIG_ZERO;
            end else if (r_state == ST_SCAN) begin
                r_dig[p] <= n_dig[p];
            end
        end
        if (r_state == ST_SCAN && prime && (r_cnt < CNT_W'(MAX_RES))) begin
            r_pend_care           <= care;
            r_pend_val            <= val;
            r_res.care_mask       <= FIELD_W'(r_pend_care);
            r_res.value_bits      <= FIELD_W'(r_pend_val);
            r_res.empty_res       <= 1'b0;
            r_res.last_result     <= 1'b0;
        end else if (r_state == ST_FLUSH) begin
            if ((i_onset & i_live) == '0) begin
                r_res <= '{care_mask: '0, value_bits: '0, empty_res: 1'b1,
                           last_result: 1'b1};
            end else begin
                r_res.care_mask   <= FIELD_W'(r_pend_care);
                r_res.value_bits  <= FIELD_W'(r_pend_val);
                r_res.empty_res   <= 1'b0;
                r_res.last_result <= 1'b1;
            end
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_clear     = (r_state == ST_FLUSH);
    assign o_res_valid = r_valid;
    assign o_res       = r_res;

endmodule

### hw/rtl/prime_implicant_generator.sv
// Prime implicant generator top level: on-set register, variable count and
// scan sequencer. Depends on pig_pkg, pig_scan.
// A minterm without last is taken into the on-set; a last minterm holds busy
// through the scan (one cube per cycle in the shared unit) and a flush state.
// One minterm per cycle unless busy; after a last, the next one at busy fall.
// Results stream unstalled. Sync reset clears the on-set, sets 4 variables, idles.
module prime_implicant_generator import pig_pkg::*; #(
    parameter int MAX_VARS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [FIELD_W-1:0] i_minterm_index,
    input  logic               i_last,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_busy,
    output logic               o_valid,
    output logic [FIELD_W-1:0] o_care_mask,
    output logic [FIELD_W-1:0] o_value_bits,
    output logic               o_empty_res,
    output logic               o_last_result
);

    localparam int NSPAN = 1 << MAX_VARS;

    logic [CFG_W-1:0]    r_num_vars;
    logic [CFG_W-1:0]    nact;
    logic [NSPAN-1:0]    r_onset, n_onset;
    logic [NSPAN-1:0]    live;
    logic [MAX_VARS-1:0] idx_mask, idx;
    logic                accept, clear;
    t_result             res;

    always_comb begin
        nact = r_num_vars;
        if (r_num_vars == '0) begin
            nact = CFG_W'(1);
        end else if (r_num_vars > CFG_W'(MAX_VARS)) begin
            nact = CFG_W'(MAX_VARS);
        end
        for (int m = 0; m < NSPAN; m++) begin
            live[m] = ((m >> int'(nact)) == 0);
        end
        for (int p = 0; p < MAX_VARS; p++) begin
            idx_mask[p] = (p < int'(nact));
        end
        idx     = i_minterm_index[MAX_VARS-1:0] & idx_mask;
        accept  = i_start && !o_busy;
        n_onset = r_onset;
        if (clear) begin
            n_onset = '0;
        end else if (accept) begin
            n_onset = r_onset | (NSPAN'(1) << idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars <= NUM_VARS_RST;
            r_onset    <= '0;
        end else begin
            r_onset <= n_onset;
            if (i_cfg_we) begin
                r_num_vars <= i_cfg_data;
            end
        end
    end

    pig_scan #(.MAX_VARS(MAX_VARS)) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (accept && i_last),
        .i_nact      (nact),
        .i_onset     (r_onset),
        .i_live      (live),
        .o_busy      (o_busy),
        .o_clear     (clear),
        .o_res_valid (o_valid),
        .o_res       (res)
    );

    assign o_care_mask   = res.care_mask;
    assign o_value_bits  = res.value_bits;
    assign o_empty_res   = res.empty_res;
    assign o_last_result = res.last_result;

    a_end_of_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> (o_valid && o_last_result))
        else $error("run ended without final result transfer");

    a_idle_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy) |-> o_last_result)
        else $error("result transfer while idle that is not the final one");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_res) |-> (o_care_mask == '0 && o_last_result))
        else $error("malformed empty result");

    a_dash_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_value_bits & ~o_care_mask) == '0))
        else $error("value bit set in a dash position");

endmodule
